// ===== rtl/core/lbcl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbcl_pkg
// Shared widths, register indexes and types of the LRU block cache lookup.
// ----------------------------------------------------------------------------
package lbcl_pkg;

    localparam int ENTRIES   = 16;
    localparam int SLOT_W    = 4;
    localparam int AGE_W     = 4;
    localparam int HELD_W    = 5;
    localparam int ADDR_W    = 48;
    localparam int IDX_W     = 39;
    localparam int COUNT_W   = 21;
    localparam int DEV_W     = 49;
    localparam int SHIFT_W   = 5;
    localparam int CAP_W     = 5;
    localparam int CFG_W     = 49;
    localparam int CFG_IDX_W = 2;
    localparam int WITHIN_W  = 20;

    localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 5'd9;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd20;
    localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;
    localparam logic [CAP_W-1:0]   MIN_CAP     = 5'd1;
    localparam logic [CAP_W-1:0]   MAX_CAP     = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BYTES = 2'd2;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              ev_valid;
        logic [IDX_W-1:0]  ev_index;
    } lru_result_t;

endpackage
`default_nettype wire

// ===== rtl/core/lbcl_lru.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbcl_lru
// Tag store and recency order: parallel tag match, free or oldest slot pick,
// and the state update for one access per cycle while update is high.
// ----------------------------------------------------------------------------
module lbcl_lru (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        update,
    input  wire logic [lbcl_pkg::IDX_W-1:0]  idx,
    input  wire logic [lbcl_pkg::CAP_W-1:0]  cap,
    output lbcl_pkg::lru_result_t            res
);
    import lbcl_pkg::*;

    logic [IDX_W-1:0]  entry_tag_reg   [ENTRIES];
    logic [ENTRIES-1:0] entry_valid_reg;
    logic [ENTRIES-1:0] entry_valid_next;
    logic [AGE_W-1:0]  entry_age_reg   [ENTRIES];
    logic [AGE_W-1:0]  entry_age_next  [ENTRIES];
    logic [HELD_W-1:0] held_count_reg;
    logic [HELD_W-1:0] held_count_next;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [SLOT_W-1:0]  old_slot;
    logic               any_hit;
    logic               any_free;
    logic               have_free;
    logic [AGE_W-1:0]   hit_age;
    logic [AGE_W-1:0]   oldest_age;

    // ages among valid entries are a permutation of 0..held-1
    assign oldest_age = AGE_W'(held_count_reg - HELD_W'(1));

    always_comb
    begin
        hit_slot  = '0;
        free_slot = '0;
        old_slot  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = entry_valid_reg[i] && (entry_tag_reg[i] == idx);
            oldest_vec[i] = entry_valid_reg[i] && (entry_age_reg[i] == oldest_age);
        end
        // lowest index wins
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                hit_slot = SLOT_W'(i);
            if (!entry_valid_reg[i])
                free_slot = SLOT_W'(i);
            if (oldest_vec[i])
                old_slot = SLOT_W'(i);
        end
        any_hit   = |match_vec;
        any_free  = ~&entry_valid_reg;
        have_free = (held_count_reg < cap) && any_free;
        hit_age   = entry_age_reg[hit_slot];

        res.hit      = any_hit;
        res.ev_valid = 1'b0;
        res.ev_index = '0;
        if (any_hit)
            res.slot = hit_slot;
        else if (have_free)
            res.slot = free_slot;
        else
        begin
            res.slot     = old_slot;
            res.ev_valid = entry_valid_reg[old_slot];
            res.ev_index = entry_tag_reg[old_slot];
        end

        entry_valid_next = entry_valid_reg;
        held_count_next  = held_count_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            entry_age_next[i] = entry_age_reg[i];
            if (any_hit)
            begin
                if (entry_valid_reg[i] && entry_age_reg[i] < hit_age)
                    entry_age_next[i] = entry_age_reg[i] + AGE_W'(1);
            end
            else if (entry_valid_reg[i])
                entry_age_next[i] = entry_age_reg[i] + AGE_W'(1);
        end
        entry_age_next[res.slot]   = '0;
        entry_valid_next[res.slot] = 1'b1;
        if (!any_hit && !res.ev_valid)
            held_count_next = held_count_reg + HELD_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            held_count_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
                entry_age_reg[i] <= '0;
        end
        else if (update)
        begin
            entry_valid_reg <= entry_valid_next;
            held_count_reg  <= held_count_next;
            for (int i = 0; i < ENTRIES; i++)
                entry_age_reg[i] <= entry_age_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && !any_hit)
            entry_tag_reg[res.slot] <= idx;
    end

endmodule
`default_nettype wire

// ===== rtl/core/lru_block_cache_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_block_cache_lookup
// Tag and LRU replacement engine of a 16-entry fully associative block cache.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one read step: byte_offset and
// want_bytes. Output channel (out_valid/out_stall) returns one result per
// step: hit, slot, fetch_index, eviction info and copy_count/more.
// A transfer takes place when valid is high and stall is low.
// A step waits in the input register, then tag match, recency update and
// length calculation complete into the result register. One step per cycle
// is sustained while out_stall is low; the recency state is updated in the
// same cycle that forms each result, so the following step sees it.
// When the receiver stalls, the result register holds and one more step can
// wait in the input register; in_stall rises only when both are full.
// Reset clears all valid bits, ages, the held count and the pipeline, and
// loads block_shift 12, capacity 16, device_bytes 0. The user must write
// configuration (cfg_write/cfg_index/cfg_data) only while idle; not enforced.
// ----------------------------------------------------------------------------
module lru_block_cache_lookup (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [lbcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lbcl_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output      logic                           in_stall,
    input  wire logic [lbcl_pkg::ADDR_W-1:0]    byte_offset,
    input  wire logic [lbcl_pkg::COUNT_W-1:0]   want_bytes,
    output      logic                           out_valid,
    input  wire logic                           out_stall,
    output      logic                           hit,
    output      logic [lbcl_pkg::SLOT_W-1:0]    slot,
    output      logic [lbcl_pkg::IDX_W-1:0]     fetch_index,
    output      logic                           evicted_valid,
    output      logic [lbcl_pkg::IDX_W-1:0]     evicted_index,
    output      logic [lbcl_pkg::COUNT_W-1:0]   copy_count,
    output      logic                           more
);
    import lbcl_pkg::*;

    logic [SHIFT_W-1:0] block_shift_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic [DEV_W-1:0]   device_bytes_reg;

    logic               s1_vld_reg;
    logic [ADDR_W-1:0]  s1_off_reg;
    logic [COUNT_W-1:0] s1_want_reg;

    logic               out_vld_reg;
    logic               hit_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [IDX_W-1:0]   fetch_reg;
    logic               ev_vld_reg;
    logic [IDX_W-1:0]   ev_idx_reg;
    logic [COUNT_W-1:0] copy_reg;

    logic               advance;
    logic               in_take;
    logic [SHIFT_W-1:0] sh;
    logic [CAP_W-1:0]   cap;
    logic [IDX_W-1:0]   idx;
    logic [WITHIN_W:0]  bsize;
    logic [WITHIN_W:0]  blk_off;
    logic [COUNT_W-1:0] room;
    logic               dev_past;
    logic [DEV_W-1:0]   dev_rem;
    logic [COUNT_W-1:0] dev_rem_sat;
    logic [COUNT_W-1:0] copy_a;
    logic [COUNT_W-1:0] copy_next;
    lru_result_t        lru_res;

    assign advance  = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = s1_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (block_shift_reg < MIN_SHIFT)
            sh = MIN_SHIFT;
        else if (block_shift_reg > MAX_SHIFT)
            sh = MAX_SHIFT;
        else
            sh = block_shift_reg;

        if (capacity_reg < MIN_CAP)
            cap = MIN_CAP;
        else if (capacity_reg > MAX_CAP)
            cap = MAX_CAP;
        else
            cap = capacity_reg;
    end

    assign idx = IDX_W'(s1_off_reg >> sh);

    // start + offset in block == offset, so the span left to the device end
    // is device_bytes - offset; copy is the least of that, block room and want
    always_comb
    begin
        bsize       = (WITHIN_W + 1)'(1) << sh;
        blk_off     = {1'b0, s1_off_reg[WITHIN_W-1:0]} & (bsize - (WITHIN_W + 1)'(1));
        room        = COUNT_W'(bsize - blk_off);
        dev_past    = device_bytes_reg > {1'b0, s1_off_reg};
        dev_rem     = device_bytes_reg - {1'b0, s1_off_reg};
        dev_rem_sat = (|dev_rem[DEV_W-1:COUNT_W]) ? '1 : dev_rem[COUNT_W-1:0];
        copy_a      = (room < dev_rem_sat) ? room : dev_rem_sat;
        if (!dev_past)
            copy_next = '0;
        else if (s1_want_reg < copy_a)
            copy_next = s1_want_reg;
        else
            copy_next = copy_a;
    end

    lbcl_lru u_lru (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .idx    (idx),
        .cap    (cap),
        .res    (lru_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg  <= RESET_SHIFT;
            capacity_reg     <= MAX_CAP;
            device_bytes_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BLOCK_SHIFT:  block_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_CAPACITY:     capacity_reg     <= cfg_data[CAP_W-1:0];
                CFG_DEVICE_BYTES: device_bytes_reg <= cfg_data[DEV_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= in_take || (s1_vld_reg && !advance);
            out_vld_reg <= advance || (out_vld_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_off_reg  <= byte_offset;
            s1_want_reg <= want_bytes;
        end
        if (advance)
        begin
            hit_reg    <= lru_res.hit;
            slot_reg   <= lru_res.slot;
            fetch_reg  <= lru_res.hit ? '0 : idx;
            ev_vld_reg <= lru_res.ev_valid;
            ev_idx_reg <= lru_res.ev_valid ? lru_res.ev_index : '0;
            copy_reg   <= copy_next;
        end
    end

    assign out_valid     = out_vld_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign fetch_index   = fetch_reg;
    assign evicted_valid = ev_vld_reg;
    assign evicted_index = ev_idx_reg;
    assign copy_count    = copy_reg;
    assign more          = |copy_reg;

endmodule
`default_nettype wire
